// ===== sv/mrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MAC rule table.
// No dependencies; every other file of the block imports this package.
package mrt_pkg;

  // Default sizing for the top level.
  localparam int unsigned EntriesDef   = 64;
  localparam int unsigned MinHeaderDef = 14;

  // Field widths.
  localparam int unsigned MacW   = 48;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned RoomW  = 8;
  localparam int unsigned BytesW = 16;
  localparam int unsigned VerdW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned HeldW  = 7;
  localparam int unsigned ErrPktW = 32;
  localparam int unsigned ErrByteW = 48;

  // Request modes.
  localparam logic [ModeW-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [ModeW-1:0] MODE_ADD    = 2'd1;
  localparam logic [ModeW-1:0] MODE_DEL    = 2'd2;

  // Rule kinds.
  localparam logic [KindW-1:0] KIND_FILTER  = 2'd0;
  localparam logic [KindW-1:0] KIND_NOPROC  = 2'd1;
  localparam logic [KindW-1:0] KIND_MACPROC = 2'd2;
  localparam logic [KindW-1:0] KIND_BAD     = 2'd3;

  // Lookup verdicts.
  localparam logic [VerdW-1:0] VERD_DROP    = 2'd0;
  localparam logic [VerdW-1:0] VERD_NOPATH  = 2'd1;
  localparam logic [VerdW-1:0] VERD_CONT    = 2'd2;
  localparam logic [VerdW-1:0] VERD_MACPROC = 2'd3;

  // Command status codes.
  localparam logic [StatW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatW-1:0] STAT_NORULE  = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL    = 2'd2;
  localparam logic [StatW-1:0] STAT_BADKIND = 2'd3;

  // Operation carried by a token through the cell chain.
  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_ADD,
    OP_DEL
  } op_e;

  // Token that walks the chain, one cell per cycle, gathering scan results.
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [MacW-1:0]  mac;
    logic [KindW-1:0] kind;
    logic             hit;
    logic [KindW-1:0] hit_kind;
    logic             free_found;
  } token_t;

  // Write of a new entry into the slot chosen by the scan.
  typedef struct packed {
    logic             en;
    logic [MacW-1:0]  mac;
    logic [KindW-1:0] kind;
  } commit_t;

endpackage

// ===== sv/mrt_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the MAC rule table.
// Depends on mrt_pkg for the field widths.
interface mrt_req_if import mrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [MacW-1:0]   mac;
  logic [KindW-1:0]  rule_kind;
  logic [RoomW-1:0]  header_room;
  logic [BytesW-1:0] packet_bytes;

  modport source (output valid, mode, mac, rule_kind, header_room, packet_bytes,
                  input ready);
  modport sink   (input valid, mode, mac, rule_kind, header_room, packet_bytes,
                  output ready);
endinterface

interface mrt_rsp_if import mrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VerdW-1:0]    verdict;
  logic [StatW-1:0]    status;
  logic [HeldW-1:0]    rules_held;
  logic [ErrPktW-1:0]  error_packets;
  logic [ErrByteW-1:0] error_byte_total;

  modport source (output valid, verdict, status, rules_held, error_packets,
                  error_byte_total, input ready);
  modport sink   (input valid, verdict, status, rules_held, error_packets,
                  error_byte_total, output ready);
endinterface

// ===== sv/mrt_cell.sv =====
`timescale 1ns / 1ps
// One table slot of the MAC rule table, a link of the scan chain.
// Depends on mrt_pkg for the token and commit types.
module mrt_cell import mrt_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDef,
  parameter int unsigned INDEX   = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  token_t                       tok_i,
  input  logic [$clog2(ENTRIES)-1:0]   free_idx_i,
  input  commit_t                      commit_i,
  input  logic [$clog2(ENTRIES)-1:0]   commit_idx_i,
  output token_t                       tok_o,
  output logic [$clog2(ENTRIES)-1:0]   free_idx_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic             valid_q;
  logic [MacW-1:0]  mac_q;
  logic [KindW-1:0] kind_q;
  token_t           tok_d, tok_q;
  logic [IdxW-1:0]  free_d, free_q;
  logic             match;
  logic             commit_me;

  assign match     = tok_i.valid && valid_q && (mac_q == tok_i.mac);
  assign commit_me = commit_i.en && (commit_idx_i == IdxW'(INDEX));

  always_comb begin
    tok_d  = tok_i;
    free_d = free_idx_i;
    if (match) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_kind = kind_q;
    end
    // The first empty slot the token passes is the lowest free one.
    if (tok_i.valid && !valid_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      free_d           = IdxW'(INDEX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (commit_me) begin
        valid_q <= 1'b1;
      end else if (match && tok_i.op == OP_DEL) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    free_q <= free_d;
    if (commit_me) begin
      mac_q  <= commit_i.mac;
      kind_q <= commit_i.kind;
    end else if (match && tok_i.op == OP_ADD) begin
      kind_q <= tok_i.kind;
    end
  end

  assign tok_o      = tok_q;
  assign free_idx_o = free_q;

endmodule

// ===== sv/mac_rule_table_top.sv =====
`timescale 1ns / 1ps
// Top level of the MAC rule table: control, counters and the cell chain.
// Depends on mrt_pkg, mrt_req_if / mrt_rsp_if and mrt_cell.
//
// Usage:
//   Requests arrive on req_i (valid/ready). A request is a lookup for a
//   received packet, an add of a rule or a delete of a rule. Every request
//   gives exactly one response on rsp_o (valid/ready), in request order.
//   The table is a chain of ENTRIES cells, one slot each. A lookup, add or
//   delete sends a token down the chain, one cell per cycle, which finds the
//   matching slot and the lowest free slot; a new entry is written into that
//   free slot when the token leaves the chain.
//   A request that scans the table goes from the launch register through
//   every cell in turn to the result state, which loads the response
//   register. A short-header lookup, an add with an invalid rule kind and
//   an unused mode skip the scan and go straight to the result state.
//   The chain length sets the scan time; one request is worked on at a time.
//   The response sits in an output register, so the next request is taken
//   while a response still waits. If the receiver stalls with a response
//   still held, a finished request waits until the register frees up.
//   Reset clears every slot's valid bit, the rule count and both error
//   counters at once; no clearing pass is needed.
module mac_rule_table_top import mrt_pkg::*; #(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned MIN_HEADER = MinHeaderDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrt_req_if.sink   req_i,
  mrt_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e               state_d, state_q;
  token_t               launch_d, launch_q;
  logic [CntW-1:0]      count_d, count_q;
  logic [ErrPktW-1:0]   err_pkts_d, err_pkts_q;
  logic [ErrByteW-1:0]  err_bytes_d, err_bytes_q;
  logic [VerdW-1:0]     res_verd_d, res_verd_q;
  logic [StatW-1:0]     res_stat_d, res_stat_q;
  logic                 rsp_valid_d, rsp_valid_q;
  logic [VerdW-1:0]     rsp_verd_d, rsp_verd_q;
  logic [StatW-1:0]     rsp_stat_d, rsp_stat_q;
  logic [HeldW-1:0]     rsp_held_d, rsp_held_q;
  logic [ErrPktW-1:0]   rsp_pkts_d, rsp_pkts_q;
  logic [ErrByteW-1:0]  rsp_bytes_d, rsp_bytes_q;
  logic [CntW+HeldW-1:0] held_ext;

  token_t               tok_chain  [0:ENTRIES];
  logic [IdxW-1:0]      free_chain [0:ENTRIES];
  commit_t              commit;
  token_t               tail;

  // Chain of table slots. The token enters at cell 0 and leaves at the end.
  assign tok_chain[0]  = launch_q;
  assign free_chain[0] = '0;
  assign tail          = tok_chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mrt_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tok_i        (tok_chain[i]),
      .free_idx_i   (free_chain[i]),
      .commit_i     (commit),
      .commit_idx_i (free_chain[ENTRIES]),
      .tok_o        (tok_chain[i+1]),
      .free_idx_o   (free_chain[i+1])
    );
  end

  // The rule count is reported modulo 128 for very large tables.
  assign held_ext = {{HeldW{1'b0}}, count_q};

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    launch_d    = launch_q;
    launch_d.valid = 1'b0;
    count_d     = count_q;
    err_pkts_d  = err_pkts_q;
    err_bytes_d = err_bytes_q;
    res_verd_d  = res_verd_q;
    res_stat_d  = res_stat_q;
    rsp_valid_d = rsp_valid_q;
    rsp_verd_d  = rsp_verd_q;
    rsp_stat_d  = rsp_stat_q;
    rsp_held_d  = rsp_held_q;
    rsp_pkts_d  = rsp_pkts_q;
    rsp_bytes_d = rsp_bytes_q;
    commit      = '0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          launch_d.mac        = req_i.mac;
          launch_d.kind       = req_i.rule_kind;
          launch_d.hit        = 1'b0;
          launch_d.hit_kind   = KIND_FILTER;
          launch_d.free_found = 1'b0;
          launch_d.op         = OP_LOOKUP;
          res_verd_d          = VERD_DROP;
          res_stat_d          = STAT_OK;
          state_d             = ST_RESULT;
          unique case (req_i.mode)
            MODE_LOOKUP: begin
              if (req_i.header_room < RoomW'(MIN_HEADER)) begin
                // Too little header room: count as an error packet and drop.
                err_pkts_d  = err_pkts_q + ErrPktW'(1);
                err_bytes_d = err_bytes_q + ErrByteW'(req_i.packet_bytes);
              end else begin
                launch_d.valid = 1'b1;
                state_d        = ST_SCAN;
              end
            end
            MODE_ADD: begin
              if (req_i.rule_kind == KIND_BAD) begin
                res_stat_d = STAT_BADKIND;
              end else begin
                launch_d.op    = OP_ADD;
                launch_d.valid = 1'b1;
                state_d        = ST_SCAN;
              end
            end
            MODE_DEL: begin
              launch_d.op    = OP_DEL;
              launch_d.valid = 1'b1;
              state_d        = ST_SCAN;
            end
            default: begin
              // Unused mode: report the counters and change nothing.
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (tail.valid) begin
          state_d    = ST_RESULT;
          res_verd_d = VERD_DROP;
          res_stat_d = STAT_OK;
          case (tail.op)
            OP_LOOKUP: begin
              if (!tail.hit) begin
                res_verd_d = VERD_CONT;
              end else if (tail.hit_kind == KIND_FILTER) begin
                res_verd_d = VERD_DROP;
              end else if (tail.hit_kind == KIND_NOPROC) begin
                res_verd_d = VERD_NOPATH;
              end else begin
                res_verd_d = VERD_MACPROC;
              end
            end
            OP_ADD: begin
              // A hit was already overwritten in place by its cell.
              if (!tail.hit) begin
                if (tail.free_found) begin
                  commit.en   = 1'b1;
                  commit.mac  = tail.mac;
                  commit.kind = tail.kind;
                  count_d     = count_q + CntW'(1);
                end else begin
                  res_stat_d = STAT_FULL;
                end
              end
            end
            default: begin
              if (!tail.hit) begin
                res_stat_d = STAT_NORULE;
              end else if (count_q != '0) begin
                count_d = count_q - CntW'(1);
              end
            end
          endcase
        end
      end

      ST_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_verd_d  = res_verd_q;
          rsp_stat_d  = res_stat_q;
          rsp_held_d  = held_ext[HeldW-1:0];
          rsp_pkts_d  = err_pkts_q;
          rsp_bytes_d = err_bytes_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= '0;
      count_q     <= '0;
      err_pkts_q  <= '0;
      err_bytes_q <= '0;
      res_verd_q  <= VERD_DROP;
      res_stat_q  <= STAT_OK;
      rsp_valid_q <= 1'b0;
      rsp_verd_q  <= VERD_DROP;
      rsp_stat_q  <= STAT_OK;
      rsp_held_q  <= '0;
      rsp_pkts_q  <= '0;
      rsp_bytes_q <= '0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      count_q     <= count_d;
      err_pkts_q  <= err_pkts_d;
      err_bytes_q <= err_bytes_d;
      res_verd_q  <= res_verd_d;
      res_stat_q  <= res_stat_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_verd_q  <= rsp_verd_d;
      rsp_stat_q  <= rsp_stat_d;
      rsp_held_q  <= rsp_held_d;
      rsp_pkts_q  <= rsp_pkts_d;
      rsp_bytes_q <= rsp_bytes_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.verdict          = rsp_verd_q;
  assign rsp_o.status           = rsp_stat_q;
  assign rsp_o.rules_held       = rsp_held_q;
  assign rsp_o.error_packets    = rsp_pkts_q;
  assign rsp_o.error_byte_total = rsp_bytes_q;

`ifndef SYNTHESIS
  // The rule count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("rule count above table size");

  // A token only leaves the chain while a scan is in progress.
  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> state_q == ST_SCAN)
    else $error("token left the chain outside a scan");

  // Writing a new entry raises the rule count by one.
  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit.en |=> count_q == $past(count_q) + CntW'(1))
    else $error("new entry did not raise the rule count");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> state_q != ST_IDLE)
    else $error("request accepted but control stayed idle");
`endif

endmodule
